/* sv/oair_pkg.sv */
// Shared types and constants for the ordered array insert/remove block.
// Used by the controller, datapath and top level; depends on nothing.
package oair_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned DATA_W_DEF = 32;

  // Field widths fixed by the interface.
  localparam int unsigned OPC_W      = 2;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned STS_W      = 2;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 40;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [CNT_W-1:0] MAX_COUNT_RST = CNT_W'(16);

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } opcode_e;

  typedef enum logic [STS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_RD_PREV,
    DP_WR_UP,
    DP_RD_NEXT,
    DP_WR_DOWN,
    DP_WR_NEW,
    DP_RD_POS,
    DP_CAPTURE,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    at_pos;
    logic    at_last;
  } dp_sts_t;

endpackage

/* sv/ordered_array_insert_remove.sv */
// Top level of the ordered array with insert, remove and read by position.
// Depends on oair_pkg, oair_ctrl and oair_dp; holds the configuration register.
//
// Channel   Direction  Handshake             Payload
// s_axis    in         tvalid/tready         tuser: opcode; tdata: position, data
// m_axis    out        tvalid/tready         tdata: status, read_data, length, full_res
// apb       in/out     psel/penable/pready   max_count at byte address 0
//
// Sequencing: one transaction at a time. A failed operation or no-op goes from
// the check straight to the result; a read first reads and captures the entry;
// an insert moves entries up, then writes the new one; a remove moves entries
// down. Each shift uses the single write and single read port of the entry RAM,
// three controller steps per entry. The next item is accepted in the cycle
// after the result is loaded, even while that result still waits on m_axis.
// Reset clears the count and the state machine; entry contents are not reset.
// A stall on m_axis holds the finished result and the following item in its
// last step until the output register frees up.
module ordered_array_insert_remove #(
  parameter int unsigned DEPTH      = oair_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oair_pkg::DATA_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: position[4:0], data[36:5], zero fill [39:37].
  input  logic [oair_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser from bit 0: opcode[1:0].
  input  logic [oair_pkg::OPC_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: status[1:0], read_data[33:2], length[38:34], full_res[39].
  output logic [oair_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oair_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [oair_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [oair_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import oair_pkg::*;

  logic [CNT_W-1:0]      max_count_q;
  logic                  cfg_sel;
  cmd_t                  cmd;
  dp_sts_t               sts;
  status_e               res_status;
  logic [OUT_DATA_W-1:0] res_rdata;
  logic [CNT_W-1:0]      res_length;
  logic                  res_full;

  // The only register sits at byte address 0; bit 2 picks the next word.
  assign pready  = 1'b1;
  assign cfg_sel = !paddr[2];
  assign prdata  = cfg_sel ? APB_DATA_W'(max_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q <= MAX_COUNT_RST;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      max_count_q <= pwdata[CNT_W-1:0];
    end
  end

  oair_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  oair_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_opcode_i  (opcode_e'(s_axis_tuser)),
    .in_pos_i     (s_axis_tdata[POS_W-1:0]),
    .in_data_i    (s_axis_tdata[POS_W+IN_DATA_W-1:POS_W]),
    .max_count_i  (max_count_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .res_status_o (res_status),
    .res_rdata_o  (res_rdata),
    .res_length_o (res_length),
    .res_full_o   (res_full)
  );

  assign m_axis_tdata = {res_full, res_length, res_rdata, res_status};

endmodule

/* sv/oair_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the datapath to hold the list entries.
module oair_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/oair_ctrl.sv */
// Controller state machine: sequences checks, entry shifts and result hand-off.
// Depends on oair_pkg; drives the datapath through cmd_t and reads dp_sts_t.
module oair_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  oair_pkg::dp_sts_t sts_i,
  output oair_pkg::cmd_t    cmd_o
);

  import oair_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_RD,
    S_INS_WR,
    S_INS_NEW,
    S_REM_CHK,
    S_REM_RD,
    S_REM_WR,
    S_RD_MEM,
    S_RD_CAP,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    m_valid_q, m_valid_d;
  logic    out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    m_valid_d  = m_valid_q && !m_ready_i;
    cmd_o.op   = DP_NOP;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = DP_LOAD;
          status_d = ST_DONE;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts_i.op)
          OP_INSERT: begin
            if (sts_i.full) begin
              status_d = ST_FULL;
              state_d  = S_FINISH;
            end else if (sts_i.pos_gt_cnt) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else begin
              state_d = S_INS_CHK;
            end
          end
          OP_REMOVE: begin
            if (sts_i.pos_ge_cnt) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else begin
              state_d = S_REM_CHK;
            end
          end
          OP_READ: begin
            if (sts_i.pos_ge_cnt) begin
              status_d = ST_RANGE;
              state_d  = S_FINISH;
            end else begin
              state_d = S_RD_MEM;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_INS_CHK: begin
        state_d = sts_i.at_pos ? S_INS_NEW : S_INS_RD;
      end
      S_INS_RD: begin
        cmd_o.op = DP_RD_PREV;
        state_d  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.op = DP_WR_UP;
        state_d  = S_INS_CHK;
      end
      S_INS_NEW: begin
        cmd_o.op = DP_WR_NEW;
        state_d  = S_FINISH;
      end
      S_REM_CHK: begin
        state_d = sts_i.at_last ? S_FINISH : S_REM_RD;
      end
      S_REM_RD: begin
        cmd_o.op = DP_RD_NEXT;
        state_d  = S_REM_WR;
      end
      S_REM_WR: begin
        cmd_o.op = DP_WR_DOWN;
        state_d  = S_REM_CHK;
      end
      S_RD_MEM: begin
        cmd_o.op = DP_RD_POS;
        state_d  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd_o.op = DP_CAPTURE;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.op  = DP_RESULT;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      status_q  <= ST_DONE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      status_q  <= status_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

/* sv/oair_dp.sv */
// Datapath: item registers, element count, shift index, entry RAM and result.
// Depends on oair_pkg and oair_ram; steered by the controller's cmd_t.
module oair_dp #(
  parameter int unsigned DEPTH      = oair_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = oair_pkg::DATA_W_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oair_pkg::opcode_e                  in_opcode_i,
  input  logic [oair_pkg::POS_W-1:0]         in_pos_i,
  input  logic [oair_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic [oair_pkg::CNT_W-1:0]         max_count_i,
  input  oair_pkg::cmd_t                     cmd_i,
  output oair_pkg::dp_sts_t                  sts_o,
  output oair_pkg::status_e                  res_status_o,
  output logic [oair_pkg::OUT_DATA_W-1:0]    res_rdata_o,
  output logic [oair_pkg::CNT_W-1:0]         res_length_o,
  output logic                               res_full_o
);

  import oair_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  opcode_e               op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [DATA_WIDTH-1:0] rd_q;
  logic [CNT_W-1:0]      idx_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      cap;
  logic [CNT_W:0]        idx_inc;

  status_e               res_status_q;
  logic [OUT_DATA_W-1:0] res_rdata_q;
  logic [CNT_W-1:0]      res_length_q;
  logic                  res_full_q;

  logic                  ram_we, ram_re;
  logic [CNT_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  // A capacity above the built depth acts as the depth.
  assign cap     = (32'(max_count_i) > DEPTH) ? CNT_W'(DEPTH) : max_count_i;
  assign idx_inc = {1'b0, idx_q} + {{CNT_W{1'b0}}, 1'b1};

  assign sts_o.op         = op_q;
  assign sts_o.full       = (cnt_q >= cap);
  assign sts_o.pos_gt_cnt = (pos_q > cnt_q);
  assign sts_o.pos_ge_cnt = (pos_q >= cnt_q);
  assign sts_o.at_pos     = (idx_q == pos_q);
  assign sts_o.at_last    = (idx_inc == {1'b0, cnt_q});

  assign ram_we = (cmd_i.op == DP_WR_UP) || (cmd_i.op == DP_WR_DOWN) ||
                  (cmd_i.op == DP_WR_NEW);
  assign ram_re = (cmd_i.op == DP_RD_PREV) || (cmd_i.op == DP_RD_NEXT) ||
                  (cmd_i.op == DP_RD_POS);

  assign waddr     = (cmd_i.op == DP_WR_NEW) ? pos_q : idx_q;
  assign ram_wdata = (cmd_i.op == DP_WR_NEW) ? data_q : ram_rdata;

  always_comb begin
    case (cmd_i.op)
      DP_RD_PREV: raddr = idx_q - CNT_W'(1);
      DP_RD_NEXT: raddr = idx_inc[CNT_W-1:0];
      default:    raddr = pos_q;
    endcase
  end

  oair_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(waddr)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AW'(raddr)),
    .rdata_o (ram_rdata)
  );

  // The count moves only when a successful insert or remove reports.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.status == ST_DONE) begin
      if (op_q == OP_INSERT) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (op_q == OP_REMOVE) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.op == DP_RESULT) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        op_q   <= in_opcode_i;
        pos_q  <= in_pos_i;
        data_q <= DATA_WIDTH'(in_data_i);
        rd_q   <= '0;
        idx_q  <= (in_opcode_i == OP_INSERT) ? cnt_q : in_pos_i;
      end
      DP_WR_UP:   idx_q <= idx_q - CNT_W'(1);
      DP_WR_DOWN: idx_q <= idx_inc[CNT_W-1:0];
      DP_CAPTURE: rd_q  <= ram_rdata;
      DP_RESULT: begin
        res_status_q <= cmd_i.status;
        res_rdata_q  <= OUT_DATA_W'(rd_q);
        res_length_q <= cnt_d;
        res_full_q   <= (cnt_d >= cap);
      end
      default: begin
      end
    endcase
  end

  assign res_status_o = res_status_q;
  assign res_rdata_o  = res_rdata_q;
  assign res_length_o = res_length_q;
  assign res_full_o   = res_full_q;

`ifndef NO_ASSERTIONS
  a_cnt_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("element count exceeds the built depth");

  a_write_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (waddr <= cnt_q))
    else $error("entry write beyond the end of the list");

  a_capture_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == DP_CAPTURE) |-> $past(cmd_i.op == DP_RD_POS))
    else $error("read data captured without a preceding RAM read");
`endif

endmodule
